@@ hw/rtl/vps_pkg.sv @@
// ----------------------------------------------------------------------------
// Vertex Phong shader package
// Field widths, stream packing, register indexes and sideband types shared by
// the shader pipeline and its arithmetic units.
// ----------------------------------------------------------------------------
package vps_pkg;

    localparam int POS_W     = 16;
    localparam int NORM_W    = 16;
    localparam int COL_W     = 9;
    localparam int OUT_W     = 16;
    localparam int DIFF_W    = POS_W + 1;
    localparam int SQR_W     = 2 * POS_W + 2;
    localparam int RAD_W     = SQR_W + 16;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int DIV_PRE   = 7;

    localparam int CFG_W     = 16;
    localparam int CFG_AW    = 3;

    localparam int S_FIELD_W = 3 * POS_W + 3 * NORM_W + 6 * COL_W;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = 3 * OUT_W;

    localparam int NORM_OFS  = 3 * POS_W;
    localparam int DIF_OFS   = NORM_OFS + 3 * NORM_W;
    localparam int SPC_OFS   = DIF_OFS + 3 * COL_W;

    typedef enum logic [CFG_AW-1:0] {
        CFG_MODE,
        CFG_LPOS_X,
        CFG_LPOS_Y,
        CFG_LPOS_Z,
        CFG_INTENSITY,
        CFG_AMBIENT
    } t_cfg_idx;

    typedef struct packed {
        logic                    mode;
        logic [2:0]              neg;
        logic [2:0][NORM_W-1:0]  norm;
        logic [2:0][COL_W-1:0]   dif;
        logic [2:0][COL_W-1:0]   spc;
    } t_vert;

    typedef struct packed {
        t_vert                   vert;
        logic [2:0][DIFF_W-1:0]  amag;
    } t_sq_side;

endpackage

@@ hw/rtl/vps_sqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Restoring digit recurrence, one root bit per register stage, with a
// sideband word and a valid bit carried alongside.
// ----------------------------------------------------------------------------
module vps_sqrt #(
    parameter int SIDE_W = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [vps_pkg::RAD_W-1:0]   i_rad,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic [vps_pkg::ROOT_W-1:0]  o_root,
    output logic [SIDE_W-1:0]           o_side
);

    localparam int RAD_W  = vps_pkg::RAD_W;
    localparam int ROOT_W = vps_pkg::ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int NSTG   = ROOT_W;

    logic              r_vld  [NSTG];
    logic [REM_W-1:0]  r_rem  [NSTG];
    logic [ROOT_W-1:0] r_root [NSTG];
    logic [RAD_W-1:0]  r_rad  [NSTG-1];
    logic [SIDE_W-1:0] r_side [NSTG];

    for (genvar k = 0; k < NSTG; k++) begin : g_stage
        logic              w_v;
        logic [REM_W-1:0]  w_rem;
        logic [ROOT_W-1:0] w_root;
        logic [RAD_W-1:0]  w_rad;
        logic [SIDE_W-1:0] w_side;
        logic [REM_W+1:0]  n_cur;
        logic [REM_W+1:0]  n_trial;

        if (k == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_rad  = i_rad;
            assign w_side = i_side;
        end else begin : g_next
            assign w_v    = r_vld[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_rad  = r_rad[k-1];
            assign w_side = r_side[k-1];
        end

        assign n_cur   = {w_rem, w_rad[RAD_W-1-2*k -: 2]};
        assign n_trial = {2'b00, w_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= w_side;
                if (n_cur >= n_trial) begin
                    r_rem[k]  <= REM_W'(n_cur - n_trial);
                    r_root[k] <= {w_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= REM_W'(n_cur);
                    r_root[k] <= {w_root[ROOT_W-2:0], 1'b0};
                end
            end
        end

        if (k < NSTG - 1) begin : g_rad
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad[k] <= w_rad;
                end
            end
        end
    end

    assign o_valid = r_vld[NSTG-1];
    assign o_root  = r_root[NSTG-1];
    assign o_side  = r_side[NSTG-1];

endmodule

@@ hw/rtl/vps_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined three-lane divider
// Restoring division of three light vector magnitudes by a shared length,
// one quotient bit per register stage in each lane.
// ----------------------------------------------------------------------------
module vps_div #(
    parameter int QUO_W  = 15,
    parameter int SIDE_W = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic [vps_pkg::ROOT_W-1:0]         i_mag,
    input  logic [2:0][vps_pkg::DIFF_W-1:0]    i_num,
    input  logic [SIDE_W-1:0]                  i_side,
    output logic                               o_valid,
    output logic [vps_pkg::ROOT_W-1:0]         o_mag,
    output logic [2:0][QUO_W-1:0]              o_quo,
    output logic [SIDE_W-1:0]                  o_side
);

    localparam int ROOT_W = vps_pkg::ROOT_W;

    logic                    r_vld  [QUO_W];
    logic [ROOT_W-1:0]       r_mag  [QUO_W];
    logic [2:0][ROOT_W-1:0]  r_rem  [QUO_W];
    logic [2:0][QUO_W-1:0]   r_quo  [QUO_W];
    logic [SIDE_W-1:0]       r_side [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic                    w_v;
        logic [ROOT_W-1:0]       w_mag;
        logic [2:0][ROOT_W-1:0]  w_rem;
        logic [2:0][QUO_W-1:0]   w_quo;
        logic [SIDE_W-1:0]       w_side;
        logic [2:0][ROOT_W-1:0]  n_rem;
        logic [2:0][QUO_W-1:0]   n_quo;

        if (k == 0) begin : g_first
            always_comb begin
                for (int j = 0; j < 3; j++) begin
                    w_rem[j] = ROOT_W'({i_num[j], {vps_pkg::DIV_PRE{1'b0}}});
                end
            end
            assign w_v    = i_valid;
            assign w_mag  = i_mag;
            assign w_quo  = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_v    = r_vld[k-1];
            assign w_mag  = r_mag[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_quo  = r_quo[k-1];
            assign w_side = r_side[k-1];
        end

        always_comb begin
            logic [ROOT_W:0] t;
            for (int j = 0; j < 3; j++) begin
                t = {w_rem[j], 1'b0};
                if (t >= {1'b0, w_mag}) begin
                    n_rem[j] = ROOT_W'(t - {1'b0, w_mag});
                    n_quo[j] = {w_quo[j][QUO_W-2:0], 1'b1};
                end else begin
                    n_rem[j] = ROOT_W'(t);
                    n_quo[j] = {w_quo[j][QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_mag[k]  <= w_mag;
                r_rem[k]  <= n_rem;
                r_quo[k]  <= n_quo;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[QUO_W-1];
    assign o_mag   = r_mag[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];

endmodule

@@ hw/rtl/vertex_phong_shader.sv @@
// ----------------------------------------------------------------------------
// Vertex Phong shader
// Per-vertex ambient, diffuse and specular lighting with a directional or a
// point light, one vertex per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// The shader takes one vertex per clock while the output is not stalled and
// returns one colour per vertex in order. Three stages form the light vector
// length, the square root takes one stage per root bit (25), the normalising
// divider one stage per quotient bit (NORMAL_FRAC_BITS + 1), and nine stages
// do the shading. The whole pipeline holds while a finished colour waits in
// the output register.
module vertex_phong_shader #(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [vps_pkg::CFG_AW-1:0]       i_cfg_addr,
    input  logic [vps_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, diffuse_r, diffuse_g,
    // diffuse_b, specular_r, specular_g, specular_b, zero fill
    input  logic [vps_pkg::S_TDATA_W-1:0]    i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // color_r, color_g, color_b
    output logic [vps_pkg::M_TDATA_W-1:0]    o_m_tdata
);

    localparam int F       = NORMAL_FRAC_BITS;
    localparam int POS_W   = vps_pkg::POS_W;
    localparam int NORM_W  = vps_pkg::NORM_W;
    localparam int COL_W   = vps_pkg::COL_W;
    localparam int OUT_W   = vps_pkg::OUT_W;
    localparam int DIFF_W  = vps_pkg::DIFF_W;
    localparam int SQR_W   = vps_pkg::SQR_W;
    localparam int ROOT_W  = vps_pkg::ROOT_W;
    localparam int QUO_W   = F + 1;
    localparam int LW      = F + 2;
    localparam int PROD_W  = NORM_W + LW;
    localparam int DOT_W   = PROD_W + 2;
    localparam int M_W     = DOT_W + NORM_W + 1;
    localparam int RZ_W    = M_W + 1;
    localparam int VRM_W   = F + 11;
    localparam int VSQ_W   = 2 * VRM_W;
    localparam int VSQX_W  = VSQ_W + 1;
    localparam int Q_W     = F + 21;
    localparam int CI_W    = 2 * COL_W;
    localparam int DP_W    = CI_W + DOT_W;
    localparam int DPX_W   = DP_W + 1;
    localparam int DT_W    = DPX_W - (16 + F);
    localparam int SP_W    = CI_W + Q_W;
    localparam int SPX_W   = SP_W + 1;
    localparam int ST_W    = SPX_W - 16;
    localparam int TOT_W   = F + 26;
    localparam int POST_N  = 9;

    localparam logic [RZ_W-1:0]  RZ_LIM  = RZ_W'(1) << (F + 10);
    localparam logic [RZ_W-1:0]  RZ_HALF = RZ_W'(1) << (2 * F - 1);
    localparam logic [DPX_W-1:0] DP_HALF = DPX_W'(1) << (15 + F);
    localparam logic [VSQX_W-1:0] SQ_HALF = VSQX_W'(1) << (F - 1);
    localparam logic [SPX_W-1:0] SP_HALF = SPX_W'(1) << 15;
    localparam logic [TOT_W-1:0] SAT_MAX = TOT_W'({OUT_W{1'b1}});

    // Configuration registers
    logic                     r_mode;
    logic signed [POS_W-1:0]  r_lpos [3];
    logic [COL_W-1:0]         r_int;
    logic [COL_W-1:0]         r_amb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b0;
            r_lpos[0] <= POS_W'(0);
            r_lpos[1] <= POS_W'(1792);
            r_lpos[2] <= POS_W'(0);
            r_int     <= COL_W'(128);
            r_amb     <= COL_W'(77);
        end else if (i_cfg_wr_en) begin
            unique case (vps_pkg::t_cfg_idx'(i_cfg_addr))
                vps_pkg::CFG_MODE:      r_mode    <= i_cfg_wdata[0];
                vps_pkg::CFG_LPOS_X:    r_lpos[0] <= i_cfg_wdata;
                vps_pkg::CFG_LPOS_Y:    r_lpos[1] <= i_cfg_wdata;
                vps_pkg::CFG_LPOS_Z:    r_lpos[2] <= i_cfg_wdata;
                vps_pkg::CFG_INTENSITY: r_int     <= i_cfg_wdata[COL_W-1:0];
                vps_pkg::CFG_AMBIENT:   r_amb     <= i_cfg_wdata[COL_W-1:0];
                default: ;
            endcase
        end
    end

    logic w_en;
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    // Light vector length front end
    logic [2:0]                r_s_vld;
    logic signed [DIFF_W-1:0]  w_p    [3];
    logic signed [DIFF_W-1:0]  r_s0_p [3];
    vps_pkg::t_vert            r_s0_vert;
    vps_pkg::t_vert            w_in_vert;
    logic [DIFF_W-1:0]         w_a    [3];
    logic [SQR_W-1:0]          r_s1_sq [3];
    vps_pkg::t_sq_side         r_s1_side;
    logic [SQR_W-1:0]          r_s2_sum;
    vps_pkg::t_sq_side         r_s2_side;

    always_comb begin
        w_in_vert.mode = r_mode;
        for (int i = 0; i < 3; i++) begin
            w_p[i] = DIFF_W'($signed(i_s_tdata[POS_W*i +: POS_W])) - DIFF_W'(r_lpos[i]);
            w_in_vert.neg[i]  = w_p[i][DIFF_W-1];
            w_in_vert.norm[i] = i_s_tdata[vps_pkg::NORM_OFS + NORM_W*i +: NORM_W];
            w_in_vert.dif[i]  = i_s_tdata[vps_pkg::DIF_OFS + COL_W*i +: COL_W];
            w_in_vert.spc[i]  = i_s_tdata[vps_pkg::SPC_OFS + COL_W*i +: COL_W];
            w_a[i] = r_s0_p[i][DIFF_W-1] ? DIFF_W'(DIFF_W'(0) - r_s0_p[i])
                                         : DIFF_W'(r_s0_p[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= '0;
        end else if (w_en) begin
            r_s_vld <= {r_s_vld[1:0], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_p    <= w_p;
            r_s0_vert <= w_in_vert;
            r_s1_side.vert <= r_s0_vert;
            for (int i = 0; i < 3; i++) begin
                r_s1_sq[i]          <= SQR_W'(w_a[i]) * SQR_W'(w_a[i]);
                r_s1_side.amag[i]   <= w_a[i];
            end
            r_s2_sum  <= r_s1_sq[0] + r_s1_sq[1] + r_s1_sq[2];
            r_s2_side <= r_s1_side;
        end
    end

    // Square root and normalisation
    logic                  w_sq_vld;
    logic [ROOT_W-1:0]     w_sq_root;
    vps_pkg::t_sq_side     w_sq_side;
    logic                  w_dv_vld;
    logic [ROOT_W-1:0]     w_dv_mag;
    logic [2:0][QUO_W-1:0] w_dv_quo;
    vps_pkg::t_vert        w_dv_vert;

    vps_sqrt #(
        .SIDE_W ($bits(vps_pkg::t_sq_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s_vld[2]),
        .i_rad   ({r_s2_sum, 16'b0}),
        .i_side  (r_s2_side),
        .o_valid (w_sq_vld),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    vps_div #(
        .QUO_W  (QUO_W),
        .SIDE_W ($bits(vps_pkg::t_vert))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_vld),
        .i_mag   (w_sq_root),
        .i_num   (w_sq_side.amag),
        .i_side  (w_sq_side.vert),
        .o_valid (w_dv_vld),
        .o_mag   (w_dv_mag),
        .o_quo   (w_dv_quo),
        .o_side  (w_dv_vert)
    );

    // Shading stages
    logic [POST_N-1:0]          r_p_vld;
    logic signed [LW-1:0]       n_l      [3];
    logic signed [LW-1:0]       r_p0_l   [3];
    vps_pkg::t_vert             r_p0_vert;
    logic signed [PROD_W-1:0]   r_p1_nl  [3];
    vps_pkg::t_vert             r_p1_vert;
    logic signed [LW-1:0]       r_p1_lz;
    logic signed [DOT_W-1:0]    r_p2_dot;
    logic signed [NORM_W-1:0]   r_p2_nz;
    logic signed [LW-1:0]       r_p2_lz;
    logic [CI_W-1:0]            r_p2_di  [3];
    logic [CI_W-1:0]            r_p2_si  [3];
    logic signed [M_W-1:0]      w_m;
    logic signed [M_W-1:0]      r_p3_m;
    logic [DOT_W-1:0]           r_p3_nd;
    logic                       r_p3_dneg;
    logic signed [LW-1:0]       r_p3_lz;
    logic [CI_W-1:0]            r_p3_di  [3];
    logic [CI_W-1:0]            r_p3_si  [3];
    logic [RZ_W-1:0]            w_rabs;
    logic [RZ_W-1:0]            w_rr;
    logic signed [RZ_W-1:0]     w_rz;
    logic [VRM_W-1:0]           n_vrm;
    logic [VRM_W-1:0]           r_p4_vrm;
    logic [DP_W-1:0]            r_p4_dp  [3];
    logic [CI_W-1:0]            r_p4_si  [3];
    logic [VSQ_W-1:0]           r_p5_vsq;
    logic [DT_W-1:0]            r_p5_dt  [3];
    logic [CI_W-1:0]            r_p5_si  [3];
    logic [Q_W-1:0]             r_p6_q;
    logic [DT_W-1:0]            r_p6_dt  [3];
    logic [CI_W-1:0]            r_p6_si  [3];
    logic [SP_W-1:0]            r_p7_sp  [3];
    logic [DT_W-1:0]            r_p7_dt  [3];
    logic [OUT_W-1:0]           r_out    [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (!w_dv_vert.mode) begin
                n_l[i] = (i == 2) ? (LW'(1) << F) : LW'(0);
            end else if (w_dv_mag == '0) begin
                n_l[i] = LW'(0);
            end else if (w_dv_vert.neg[i]) begin
                n_l[i] = LW'(0) - LW'(w_dv_quo[i]);
            end else begin
                n_l[i] = LW'(w_dv_quo[i]);
            end
        end
    end

    always_comb begin
        w_m    = M_W'(r_p2_dot) * M_W'(r_p2_nz);
        w_rabs = r_p3_m[M_W-1] ? RZ_W'(RZ_W'(0) - RZ_W'(r_p3_m)) : RZ_W'(r_p3_m);
        w_rr   = (w_rabs + RZ_HALF) >> (2 * F);
        w_rz   = (r_p3_m[M_W-1] ? (RZ_W'(0) - $signed(w_rr)) : $signed(w_rr))
                 + RZ_W'(r_p3_lz);
        if (r_p3_dneg && !w_rz[RZ_W-1]) begin
            n_vrm = ($unsigned(w_rz) > RZ_LIM) ? VRM_W'(RZ_LIM) : VRM_W'(w_rz);
        end else begin
            n_vrm = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= '0;
        end else if (w_en) begin
            r_p_vld <= {r_p_vld[POST_N-2:0], w_dv_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        logic [TOT_W-1:0] tot;
        if (w_en) begin
            r_p0_l    <= n_l;
            r_p0_vert <= w_dv_vert;

            r_p1_vert <= r_p0_vert;
            r_p1_lz   <= r_p0_l[2];
            for (int i = 0; i < 3; i++) begin
                r_p1_nl[i] <= PROD_W'($signed(r_p0_vert.norm[i])) * PROD_W'(r_p0_l[i]);
            end

            r_p2_dot <= DOT_W'(r_p1_nl[0]) + DOT_W'(r_p1_nl[1]) + DOT_W'(r_p1_nl[2]);
            r_p2_nz  <= $signed(r_p1_vert.norm[2]);
            r_p2_lz  <= r_p1_lz;
            for (int c = 0; c < 3; c++) begin
                r_p2_di[c] <= CI_W'(r_p1_vert.dif[c]) * CI_W'(r_int);
                r_p2_si[c] <= CI_W'(r_p1_vert.spc[c]) * CI_W'(r_int);
            end

            r_p3_m    <= (M_W'(0) - w_m) <<< 1;
            r_p3_nd   <= (r_p2_dot <= 0) ? DOT_W'(DOT_W'(0) - r_p2_dot) : DOT_W'(0);
            r_p3_dneg <= r_p2_dot[DOT_W-1];
            r_p3_lz   <= r_p2_lz;
            r_p3_di   <= r_p2_di;
            r_p3_si   <= r_p2_si;

            r_p4_vrm <= n_vrm;
            r_p4_si  <= r_p3_si;
            for (int c = 0; c < 3; c++) begin
                r_p4_dp[c] <= DP_W'(r_p3_di[c]) * DP_W'(r_p3_nd);
            end

            r_p5_vsq <= VSQ_W'(r_p4_vrm) * VSQ_W'(r_p4_vrm);
            r_p5_si  <= r_p4_si;
            for (int c = 0; c < 3; c++) begin
                r_p5_dt[c] <= DT_W'((DPX_W'(r_p4_dp[c]) + DP_HALF) >> (16 + F));
            end

            r_p6_q  <= Q_W'((VSQX_W'(r_p5_vsq) + SQ_HALF) >> F);
            r_p6_dt <= r_p5_dt;
            r_p6_si <= r_p5_si;

            r_p7_dt <= r_p6_dt;
            for (int c = 0; c < 3; c++) begin
                r_p7_sp[c] <= SP_W'(r_p6_si[c]) * SP_W'(r_p6_q);
            end

            for (int c = 0; c < 3; c++) begin
                tot = (TOT_W'(r_amb) << (F - 8)) + TOT_W'(r_p7_dt[c])
                      + TOT_W'(ST_W'((SPX_W'(r_p7_sp[c]) + SP_HALF) >> 16));
                r_out[c] <= (tot > SAT_MAX) ? {OUT_W{1'b1}} : tot[OUT_W-1:0];
            end
        end
    end

    assign o_m_tvalid = r_p_vld[POST_N-1];
    assign o_m_tdata  = {r_out[2], r_out[1], r_out[0]};

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |=> $stable(r_p_vld))
        else $error("shading stages moved during a stall");

    a_dir_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dv_vld && w_dv_vert.mode && (w_dv_mag != '0)) |->
        ((w_dv_quo[0] <= (QUO_W'(1) << F)) && (w_dv_quo[1] <= (QUO_W'(1) << F))
         && (w_dv_quo[2] <= (QUO_W'(1) << F))))
        else $error("normalised light component exceeds one");

endmodule
